FILE: design/signal_level_to_percent_macros.svh
// ----------------------------------------------------------------------------
// signal level to percent assertion macros
// shared concurrent assertion forms for the level mapper
// ----------------------------------------------------------------------------
`ifndef SIGNAL_LEVEL_TO_PERCENT_MACROS_SVH
`define SIGNAL_LEVEL_TO_PERCENT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SLP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication with a delay given by the lat argument
`define SLP_ASSERT_DELAY(label, clk, rst_n, ante, lat, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##lat (cons)) \
    else $error(msg);

`endif

FILE: design/slp_pkg.sv
// ----------------------------------------------------------------------------
// slp_pkg
// types, codes, breakpoint tables and reciprocal constants for the mapper
// ----------------------------------------------------------------------------
`default_nettype none

package slp_pkg;

  // measurement kind
  localparam logic OP_STRENGTH = 1'b0;
  localparam logic OP_QUALITY  = 1'b1;

  // radio technology
  localparam logic [2:0] TECH_GSM   = 3'd0;
  localparam logic [2:0] TECH_EDGE  = 3'd1;
  localparam logic [2:0] TECH_UTRAN = 3'd2;
  localparam logic [2:0] TECH_LTE   = 3'd3;
  localparam logic [2:0] TECH_CATM1 = 3'd4;
  localparam logic [2:0] TECH_NB1   = 3'd5;

  // divide by 100 of a magnitude of at most 32768: (a * 5243) >> 19 is exact
  localparam int RECIP_DIV100 = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int DIV_PROD_W   = 29;
  localparam int LVL_MAG_W    = 10;

  // one quarter of full scale times 100
  localparam int SCALE_QTR = 65535 * 25;

  // small reciprocal for the remainder term, 16 bit fraction
  localparam int RECIP_ONE   = 65536;
  localparam int RECIP_SHIFT = 16;

  // final divide by 100 of a 23 bit sum: (s * 10737419) >> 30 is exact
  localparam int RECIP_PCT = 10737419;
  localparam int PCT_SHIFT = 30;

  localparam logic [15:0] FULL_SCALE = 16'hFFFF;

  typedef enum logic [2:0] {
    TBL_NONE,
    TBL_STRN_GSM,
    TBL_STRN_UTRAN,
    TBL_STRN_LTE,
    TBL_QUAL_UTRAN,
    TBL_QUAL_LTE
  } slp_tbl_t;

  typedef logic signed [10:0] slp_lvl_t;
  typedef slp_lvl_t [4:0] slp_bkpts_t;

  typedef struct packed {
    logic              op;
    logic [2:0]        tech;
    logic signed [15:0] raw_level;
  } slp_in_t;

  typedef struct packed {
    logic [15:0] percent;
    logic        unsupported;
  } slp_out_t;

  // per span constants: C = q * span + rm, so d*C/span = d*q + d*rm/span
  typedef struct packed {
    logic [20:0] q;
    logic [5:0]  rm;
    logic [15:0] mrec;
  } slp_coef_t;

  // result overrides that travel beside the arithmetic
  typedef struct packed {
    logic unsup;
    logic below;
    logic above;
  } slp_flags_t;

  typedef struct packed {
    slp_tbl_t               tbl;
    logic                   neg;
    logic [DIV_PROD_W-1:0]  prod;
  } slp_s1_t;

  typedef struct packed {
    slp_flags_t flags;
    logic [1:0] region;
    logic [5:0] delta;
    slp_coef_t  coef;
  } slp_s2_t;

  typedef struct packed {
    slp_flags_t  flags;
    logic [22:0] base;
    logic [20:0] whole;
    logic [10:0] part;
    logic [15:0] mrec;
  } slp_s3_t;

  typedef struct packed {
    slp_flags_t  flags;
    logic [22:0] sum;
  } slp_s4_t;

  typedef struct packed {
    slp_flags_t  flags;
    logic [46:0] prod;
  } slp_s5_t;

  localparam slp_bkpts_t BKPT_STRN_GSM =
    {-11'sd89, -11'sd97, -11'sd103, -11'sd107, -11'sd111};
  localparam slp_bkpts_t BKPT_STRN_UTRAN =
    {-11'sd85, -11'sd95, -11'sd105, -11'sd115, -11'sd121};
  localparam slp_bkpts_t BKPT_STRN_LTE =
    {-11'sd70, -11'sd85, -11'sd95, -11'sd105, -11'sd141};
  localparam slp_bkpts_t BKPT_QUAL_UTRAN =
    {-11'sd2, -11'sd5, -11'sd10, -11'sd17, -11'sd24};
  localparam slp_bkpts_t BKPT_QUAL_LTE =
    {-11'sd6, -11'sd8, -11'sd10, -11'sd16, -11'sd20};

  function automatic slp_tbl_t pick_table(input logic op, input logic [2:0] tech);
    slp_tbl_t t;
    t = TBL_NONE;
    if (op == OP_STRENGTH) begin
      unique case (tech) inside
        TECH_GSM, TECH_EDGE:           t = TBL_STRN_GSM;
        TECH_UTRAN:                    t = TBL_STRN_UTRAN;
        TECH_LTE, TECH_CATM1, TECH_NB1: t = TBL_STRN_LTE;
        default:                       t = TBL_NONE;
      endcase
    end else begin
      unique case (tech) inside
        TECH_UTRAN:                    t = TBL_QUAL_UTRAN;
        TECH_LTE, TECH_CATM1, TECH_NB1: t = TBL_QUAL_LTE;
        default:                       t = TBL_NONE;
      endcase
    end
    return t;
  endfunction

  function automatic slp_bkpts_t table_bkpts(input slp_tbl_t tbl);
    slp_bkpts_t b;
    b = '0;
    unique case (tbl)
      TBL_STRN_GSM:   b = BKPT_STRN_GSM;
      TBL_STRN_UTRAN: b = BKPT_STRN_UTRAN;
      TBL_STRN_LTE:   b = BKPT_STRN_LTE;
      TBL_QUAL_UTRAN: b = BKPT_QUAL_UTRAN;
      TBL_QUAL_LTE:   b = BKPT_QUAL_LTE;
      default:        b = '0;
    endcase
    return b;
  endfunction

  // quotient, remainder and 16 bit reciprocal for every span in the tables
  function automatic slp_coef_t span_coef(input logic [5:0] span);
    slp_coef_t c;
    c = '0;
    unique case (span)
      6'd2: begin
        c.q = 21'(SCALE_QTR / 2); c.rm = 6'(SCALE_QTR % 2);
        c.mrec = 16'((RECIP_ONE + 1) / 2);
      end
      6'd3: begin
        c.q = 21'(SCALE_QTR / 3); c.rm = 6'(SCALE_QTR % 3);
        c.mrec = 16'((RECIP_ONE + 2) / 3);
      end
      6'd4: begin
        c.q = 21'(SCALE_QTR / 4); c.rm = 6'(SCALE_QTR % 4);
        c.mrec = 16'((RECIP_ONE + 3) / 4);
      end
      6'd5: begin
        c.q = 21'(SCALE_QTR / 5); c.rm = 6'(SCALE_QTR % 5);
        c.mrec = 16'((RECIP_ONE + 4) / 5);
      end
      6'd6: begin
        c.q = 21'(SCALE_QTR / 6); c.rm = 6'(SCALE_QTR % 6);
        c.mrec = 16'((RECIP_ONE + 5) / 6);
      end
      6'd7: begin
        c.q = 21'(SCALE_QTR / 7); c.rm = 6'(SCALE_QTR % 7);
        c.mrec = 16'((RECIP_ONE + 6) / 7);
      end
      6'd8: begin
        c.q = 21'(SCALE_QTR / 8); c.rm = 6'(SCALE_QTR % 8);
        c.mrec = 16'((RECIP_ONE + 7) / 8);
      end
      6'd10: begin
        c.q = 21'(SCALE_QTR / 10); c.rm = 6'(SCALE_QTR % 10);
        c.mrec = 16'((RECIP_ONE + 9) / 10);
      end
      6'd15: begin
        c.q = 21'(SCALE_QTR / 15); c.rm = 6'(SCALE_QTR % 15);
        c.mrec = 16'((RECIP_ONE + 14) / 15);
      end
      6'd36: begin
        c.q = 21'(SCALE_QTR / 36); c.rm = 6'(SCALE_QTR % 36);
        c.mrec = 16'((RECIP_ONE + 35) / 36);
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/slp_scale.sv
// ----------------------------------------------------------------------------
// slp_scale
// first stage: table decode and magnitude times reciprocal of 100
// ----------------------------------------------------------------------------
`default_nettype none

module slp_scale (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire slp_pkg::slp_in_t in_word,
  output logic                 s1_valid,
  output slp_pkg::slp_s1_t     s1_word
);

  logic             valid_r;
  slp_pkg::slp_s1_t s1_r;
  slp_pkg::slp_s1_t s1_nxt;
  logic [15:0]      mag;

  always_comb begin
    // -(-32768) wraps to 16'h8000, which is the right magnitude unsigned
    mag = in_word.raw_level[15] ? 16'(-in_word.raw_level) : 16'(in_word.raw_level);
    s1_nxt.tbl  = slp_pkg::pick_table(in_word.op, in_word.tech);
    s1_nxt.neg  = in_word.raw_level[15];
    s1_nxt.prod = slp_pkg::DIV_PROD_W'(mag) *
                  slp_pkg::DIV_PROD_W'(slp_pkg::RECIP_DIV100);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  assign s1_valid = valid_r;
  assign s1_word  = s1_r;

endmodule

`default_nettype wire

FILE: design/slp_region.sv
// ----------------------------------------------------------------------------
// slp_region
// second stage: signed level, breakpoint compare, region and span constants
// ----------------------------------------------------------------------------
`default_nettype none

module slp_region (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             s1_valid,
  input  wire slp_pkg::slp_s1_t s1_word,
  output logic                  s2_valid,
  output slp_pkg::slp_s2_t      s2_word
);

  logic                 valid_r;
  slp_pkg::slp_s2_t     s2_r;
  slp_pkg::slp_s2_t     s2_nxt;
  slp_pkg::slp_bkpts_t  bk;
  slp_pkg::slp_lvl_t    t [5];
  slp_pkg::slp_lvl_t    lvl;
  slp_pkg::slp_lvl_t    lo;
  slp_pkg::slp_lvl_t    hi;
  slp_pkg::slp_lvl_t    span_w;
  slp_pkg::slp_lvl_t    delta_w;
  logic [slp_pkg::LVL_MAG_W-1:0] q;
  logic [1:0]           region;

  always_comb begin
    bk = slp_pkg::table_bkpts(s1_word.tbl);
    for (int i = 0; i < 5; i++) begin
      t[i] = bk[i];
    end
    q   = s1_word.prod[slp_pkg::DIV100_SHIFT +: slp_pkg::LVL_MAG_W];
    // truncation toward zero: divide the magnitude, then restore the sign
    lvl = s1_word.neg ? -slp_pkg::slp_lvl_t'({1'b0, q}) : slp_pkg::slp_lvl_t'({1'b0, q});

    if (lvl >= t[3]) begin
      region = 2'd3;
    end else if (lvl >= t[2]) begin
      region = 2'd2;
    end else if (lvl >= t[1]) begin
      region = 2'd1;
    end else begin
      region = 2'd0;
    end

    lo      = t[region];
    hi      = t[3'({1'b0, region}) + 3'd1];
    span_w  = hi - lo;
    delta_w = lvl - lo;

    s2_nxt.flags.unsup = (s1_word.tbl == slp_pkg::TBL_NONE);
    s2_nxt.flags.below = (lvl < t[0]);
    s2_nxt.flags.above = (lvl >= t[4]);
    s2_nxt.region      = region;
    s2_nxt.delta       = delta_w[5:0];
    s2_nxt.coef        = slp_pkg::span_coef(span_w[5:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
  end

  assign s2_valid = valid_r;
  assign s2_word  = s2_r;

endmodule

`default_nettype wire

FILE: design/slp_interp.sv
// ----------------------------------------------------------------------------
// slp_interp
// stages three to five: interpolation products, sum, divide by 100
// ----------------------------------------------------------------------------
`default_nettype none

module slp_interp (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             s2_valid,
  input  wire slp_pkg::slp_s2_t s2_word,
  output logic                  s5_valid,
  output slp_pkg::slp_s5_t      s5_word
);

  logic             v3_r;
  logic             v4_r;
  logic             v5_r;
  slp_pkg::slp_s3_t s3_r;
  slp_pkg::slp_s3_t s3_nxt;
  slp_pkg::slp_s4_t s4_r;
  slp_pkg::slp_s4_t s4_nxt;
  slp_pkg::slp_s5_t s5_r;
  slp_pkg::slp_s5_t s5_nxt;
  logic [26:0]      frac_prod;
  logic [5:0]       frac;

  // stage 3: d*q, d*rm and the region base
  always_comb begin
    s3_nxt.flags = s2_word.flags;
    s3_nxt.base  = 23'(s2_word.region) * 23'(slp_pkg::SCALE_QTR);
    s3_nxt.whole = 21'(27'(s2_word.delta) * 27'(s2_word.coef.q));
    s3_nxt.part  = 11'(s2_word.delta) * 11'(s2_word.coef.rm);
    s3_nxt.mrec  = s2_word.coef.mrec;
  end

  // stage 4: floor(d*rm/span) through the small reciprocal, then the sum
  always_comb begin
    frac_prod    = 27'(s3_r.part) * 27'(s3_r.mrec);
    frac         = frac_prod[slp_pkg::RECIP_SHIFT +: 6];
    s4_nxt.flags = s3_r.flags;
    s4_nxt.sum   = s3_r.base + 23'(s3_r.whole) + 23'(frac);
  end

  // stage 5: sum times reciprocal of 100
  always_comb begin
    s5_nxt.flags = s4_r.flags;
    s5_nxt.prod  = 47'(s4_r.sum) * 47'(slp_pkg::RECIP_PCT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v3_r <= s2_valid;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_r <= s3_nxt;
    s4_r <= s4_nxt;
    s5_r <= s5_nxt;
  end

  assign s5_valid = v5_r;
  assign s5_word  = s5_r;

endmodule

`default_nettype wire

FILE: design/signal_level_to_percent.sv
// ----------------------------------------------------------------------------
// signal_level_to_percent
// maps a radio level in hundredths of dB(m) to a 0..65535 percentage through
// five-breakpoint piecewise linear tables chosen by technology and kind
// ----------------------------------------------------------------------------
//
//   channel   ports                         handshake
//   -------   ---------------------------   ---------------------------------
//   input     start, busy, in_word          word taken when start && !busy
//   result    out_valid, out_word           one-cycle strobe, no backpressure
//
// one word can enter every cycle; busy stays low
// from the accepting edge to the edge that takes the result, a word passes:
//   scale multiply, region compare, products, sum, divide by 100, output reg
// the rate is set by the pipeline, one word per cycle through every stage
// reset clears only the valid bits of each stage; data registers are free
// the result side cannot stall, so nothing in the pipe ever waits
//
`default_nettype none

module signal_level_to_percent (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire slp_pkg::slp_in_t  in_word,
  output logic                   out_valid,
  output slp_pkg::slp_out_t      out_word
);

`include "signal_level_to_percent_macros.svh"

  localparam int LATENCY = 6;

  logic              in_valid;
  logic              s1_valid;
  slp_pkg::slp_s1_t  s1_word;
  logic              s2_valid;
  slp_pkg::slp_s2_t  s2_word;
  logic              s5_valid;
  slp_pkg::slp_s5_t  s5_word;
  logic              out_valid_r;
  slp_pkg::slp_out_t out_r;
  slp_pkg::slp_out_t out_nxt;
  logic [15:0]       pct;
  logic              in_unsup;

  // fully pipelined: always ready for the next word
  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  // no table for the incoming technology and kind, for the checks below
  assign in_unsup = (slp_pkg::pick_table(in_word.op, in_word.tech) == slp_pkg::TBL_NONE);

  // stage 1: table pick and |level| * reciprocal of 100
  slp_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_word  (in_word),
    .s1_valid (s1_valid),
    .s1_word  (s1_word)
  );

  // stage 2: signed level, region search against the breakpoints
  slp_region u_region (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_word  (s1_word),
    .s2_valid (s2_valid),
    .s2_word  (s2_word)
  );

  // stages 3 to 5: interpolation within the region and final scaling
  slp_interp u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .s2_valid (s2_valid),
    .s2_word  (s2_word),
    .s5_valid (s5_valid),
    .s5_word  (s5_word)
  );

  // stage 6: clamp and override, then the output register
  always_comb begin
    pct = s5_word.prod[slp_pkg::PCT_SHIFT +: 16];
    out_nxt.unsupported = s5_word.flags.unsup;
    if (s5_word.flags.unsup || s5_word.flags.below) begin
      // no table, or level under the first breakpoint
      out_nxt.percent = '0;
    end else if (s5_word.flags.above) begin
      // at or above the last breakpoint
      out_nxt.percent = slp_pkg::FULL_SCALE;
    end else begin
      out_nxt.percent = pct;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // every accepted word comes out after the fixed latency
  `SLP_ASSERT_DELAY(a_latency, clk, rst_n, start && !busy, LATENCY, out_valid, "word lost in pipe")

  // an unsupported word reports zero
  `SLP_ASSERT_IMPLY(a_unsup_zero, clk, rst_n, out_valid && out_word.unsupported, out_word.percent == 16'd0, "unsupported result not zero")

  // a word taken in with no table for its technology and kind raises the error flag
  `SLP_ASSERT_DELAY(a_unsup_flag, clk, rst_n, start && !busy && in_unsup, LATENCY, out_word.unsupported, "unsupported flag missing")

endmodule

`default_nettype wire

FILE: verif/signal_level_to_percent_test.sv
// ----------------------------------------------------------------------------
// signal_level_to_percent_test
// self-checking bench for the level to percent mapper: a directed sweep over
// the breakpoints, extremes and unsupported combinations, then random words under
// three sender idling profiles and a drain pause, each result checked against a predictor
// ----------------------------------------------------------------------------

module signal_level_to_percent_test;
  timeunit 1ns;
  timeprecision 1ps;

  import slp_pkg::*;

  // technology codes with no table at all
  localparam logic [2:0] TECH_RSVD_LO = 3'd6;
  localparam logic [2:0] TECH_RSVD_HI = 3'd7;

  localparam int FULL_PCT     = 65535;
  localparam int PIPE_SETTLE  = 12;     // settling wait after the drain, beyond the pipeline latency, with margin
  localparam int DRAIN_LIMIT  = 2000;   // cycles allowed for the pipe to empty

  // ---------------------------------------------------------------------------
  // clock, reset and block under test
  // ---------------------------------------------------------------------------
  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  slp_in_t  in_word = '0;
  logic     busy;
  logic     out_valid;
  slp_out_t out_word;

  always #6 clk = ~clk;

  signal_level_to_percent i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // ---------------------------------------------------------------------------
  // bookkeeping
  // ---------------------------------------------------------------------------
  slp_out_t percent_due_q[$];   // predicted results, oldest first
  int       error_count   = 0;
  int       words_sent    = 0;
  int       results_seen  = 0;
  int       unsup_sent    = 0;
  int       clipped_sent  = 0;  // words that landed at or below the first or at or above the last breakpoint

  // ---------------------------------------------------------------------------
  // predictor: table lookup, truncating divide by 100, piecewise interpolation
  // ---------------------------------------------------------------------------
  function automatic slp_out_t level_to_percent(slp_in_t w);
    int       bk[5];
    int       v;
    int       r;
    logic     unsup;
    longint   frac;
    longint   pct;
    slp_out_t res;
    res   = '0;
    unsup = 1'b0;
    bk    = '{0, 0, 0, 0, 0};
    if (w.op == OP_STRENGTH) begin
      case (w.tech)
        TECH_GSM, TECH_EDGE:            bk = '{-111, -107, -103, -97, -89};
        TECH_UTRAN:                     bk = '{-121, -115, -105, -95, -85};
        TECH_LTE, TECH_CATM1, TECH_NB1: bk = '{-141, -105, -95, -85, -70};
        default:                        unsup = 1'b1;
      endcase
    end else begin
      case (w.tech)
        TECH_UTRAN:                     bk = '{-24, -17, -10, -5, -2};
        TECH_LTE, TECH_CATM1, TECH_NB1: bk = '{-20, -16, -10, -8, -6};
        default:                        unsup = 1'b1;
      endcase
    end
    if (unsup) begin
      res.unsupported = 1'b1;
      res.percent     = '0;
      return res;
    end
    // signed int division truncates toward zero
    v = int'(w.raw_level) / 100;
    if (v < bk[0]) begin
      pct = 0;
    end else if (v >= bk[4]) begin
      pct = FULL_PCT;
    end else begin
      r = 0;
      for (int i = 1; i <= 3; i++) begin
        if (v >= bk[i]) r = i;
      end
      frac = (longint'(v - bk[r]) * 25 * FULL_PCT) / longint'(bk[r + 1] - bk[r]);
      pct  = (longint'(FULL_PCT) * 25 * r + frac) / 100;
    end
    res.percent     = pct[15:0];
    res.unsupported = 1'b0;
    return res;
  endfunction

  function automatic slp_in_t level_word(logic op, logic [2:0] tech, int raw);
    slp_in_t w;
    w.op        = op;
    w.tech      = tech;
    w.raw_level = raw[15:0];
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: drive one word and hold it until the block takes it
  // start is left high so a following word can go out on the very next edge
  // ---------------------------------------------------------------------------
  task automatic send_level(slp_in_t w);
    slp_out_t due;
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
    due = level_to_percent(w);
    percent_due_q.push_back(due);
    words_sent++;
    if (due.unsupported) unsup_sent++;
    else if (due.percent == '0 || due.percent == FULL_SCALE) clipped_sent++;
  endtask

  // drop start and hold the sender idle
  task automatic hold_off(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // random sender gap: each cycle stays idle with idle_pct percent chance
  task automatic maybe_idle(int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      hold_off(1);
    end
  endtask

  // stop sending until every predicted result has come back or the drain limit runs out
  task automatic drain_results();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (percent_due_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // checker: results are one cycle strobes, compared in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    slp_out_t due;
    if (rst_n) begin
      if ($isunknown(out_valid)) begin
        $error("out_valid is unknown");
        error_count++;
      end else if (out_valid) begin
        results_seen++;
        if (percent_due_q.size() == 0) begin
          $error("result word with nothing expected: percent %0d unsupported %0b",
                 out_word.percent, out_word.unsupported);
          error_count++;
        end else begin
          due = percent_due_q.pop_front();
          if (out_word.percent !== due.percent) begin
            $error("percent: expected %0d, actual %0d", due.percent, out_word.percent);
            error_count++;
          end
          if (out_word.unsupported !== due.unsupported) begin
            $error("unsupported: expected %0b, actual %0b",
                   due.unsupported, out_word.unsupported);
            error_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // random word: mostly levels near the breakpoints of a real table
  // ---------------------------------------------------------------------------
  function automatic slp_in_t random_level_word();
    int      sel;
    int      v;
    logic    op;
    logic [2:0] tech;
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      op = 1'($urandom_range(0, 1));
      if (op == OP_STRENGTH) begin
        tech = 3'($urandom_range(TECH_GSM, TECH_NB1));
        v    = -int'($urandom_range(66, 145));
      end else begin
        tech = 3'($urandom_range(TECH_UTRAN, TECH_NB1));
        v    = int'($urandom_range(0, 30)) - 28;
      end
      // sub-dB part spread across both sides of zero to exercise truncation
      return level_word(op, tech, v * 100 + int'($urandom_range(0, 198)) - 99);
    end else if (sel < 90) begin
      // anything at all, so every raw bit toggles
      return level_word(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), int'($urandom));
    end else begin
      // combinations with no table
      case ($urandom_range(0, 2))
        0: tech = TECH_GSM;
        1: tech = TECH_EDGE;
        default: tech = $urandom_range(0, 1) ? TECH_RSVD_HI : TECH_RSVD_LO;
      endcase
      op = (tech == TECH_GSM || tech == TECH_EDGE) ? OP_QUALITY : logic'($urandom_range(0, 1));
      return level_word(op, tech, int'($urandom));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, breakpoints, truncation toward zero, every table and
  // every unsupported combination
  task automatic test_directed();
    send_level(level_word(OP_STRENGTH, TECH_LTE,   -32768));  // far below
    send_level(level_word(OP_STRENGTH, TECH_LTE,    32767));  // far above
    send_level(level_word(OP_STRENGTH, TECH_LTE,   -14150));  // truncates onto first breakpoint
    send_level(level_word(OP_STRENGTH, TECH_LTE,   -14201));  // one dB under it
    send_level(level_word(OP_STRENGTH, TECH_LTE,    -7000));  // last breakpoint
    send_level(level_word(OP_STRENGTH, TECH_LTE,    -7099));  // truncates up to last
    send_level(level_word(OP_STRENGTH, TECH_LTE,    -7101));  // top region
    send_level(level_word(OP_STRENGTH, TECH_GSM,   -10700));
    send_level(level_word(OP_STRENGTH, TECH_EDGE,   -9700));
    send_level(level_word(OP_STRENGTH, TECH_UTRAN, -11550));
    send_level(level_word(OP_STRENGTH, TECH_CATM1,  -9500));
    send_level(level_word(OP_STRENGTH, TECH_NB1,    -8599));
    send_level(level_word(OP_QUALITY,  TECH_UTRAN,  -2400));
    send_level(level_word(OP_QUALITY,  TECH_UTRAN,   -199));
    send_level(level_word(OP_QUALITY,  TECH_LTE,    -1600));
    send_level(level_word(OP_QUALITY,  TECH_CATM1,   -800));
    send_level(level_word(OP_QUALITY,  TECH_NB1,     -999));
    send_level(level_word(OP_QUALITY,  TECH_LTE,        0));
    send_level(level_word(OP_QUALITY,  TECH_LTE,      -99));  // truncates to zero dB
    send_level(level_word(OP_QUALITY,  TECH_GSM,    -5000));  // no quality table for gsm
    send_level(level_word(OP_QUALITY,  TECH_EDGE,   32767));  // nor for edge
    send_level(level_word(OP_STRENGTH, TECH_RSVD_LO, -32768));
    send_level(level_word(OP_QUALITY,  TECH_RSVD_HI,  32767));
    send_level(level_word(OP_STRENGTH, TECH_RSVD_HI,     -1));
    send_level(level_word(OP_QUALITY,  TECH_RSVD_LO,  12345));
  endtask

  // random words with the sender idling idle_pct percent of the time
  task automatic test_random_traffic(int count, int idle_pct);
    for (int n = 0; n < count; n++) begin
      maybe_idle(idle_pct);
      send_level(random_level_word());
    end
  endtask

  // back-to-back burst, full stop until the pipe is empty, then another burst
  task automatic test_drain_pause();
    for (int n = 0; n < 20; n++) send_level(random_level_word());
    drain_results();
    for (int n = 0; n < 20; n++) send_level(random_level_word());
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_traffic(430, 27);
    test_drain_pause();
    test_random_traffic(430, 72);
    test_random_traffic(430, 0);

    // let the pipe empty, then watch a few more cycles for stray results
    drain_results();
    repeat (PIPE_SETTLE) @(posedge clk);
    if (percent_due_q.size() != 0) begin
      $error("%0d results never arrived", percent_due_q.size());
      error_count++;
    end

    $display("mapped %0d words (%0d without a table, %0d clipped to an end of scale)",
             words_sent, unsup_sent, clipped_sent);
    $display("checked %0d results across busy, sparse and gap-free sending", results_seen);
    if (error_count == 0) begin
      $display("signal_level_to_percent_test OK");
    end else begin
      $display("signal_level_to_percent_test NOT OK");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #5000000;
    $display("timeout after %0d words", words_sent);
    $display("signal_level_to_percent_test NOT OK");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/slp_pkg.sv
design/slp_scale.sv
design/slp_region.sv
design/slp_interp.sv
design/signal_level_to_percent.sv
verif/signal_level_to_percent_test.sv
